>>> sv/cfb_pkg.sv
// Package for the command frame builder: item structs, header constants
// and the control struct of the CRC unit. No dependencies.
`default_nettype none

package cfb_pkg;

  localparam int unsigned MAX_DATA_BYTES_DEF = 8;

  localparam logic [7:0]  HDR_BASE      = 8'h80;
  localparam logic [7:0]  HDR_WIDE_ADDR = 8'h08;
  localparam logic [3:0]  LEN_EIGHT     = 4'd8;
  localparam logic [3:0]  LEN_SEVEN     = 4'd7;
  localparam logic [2:0]  LEN_CODE_MAX  = 3'd7;
  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

  typedef struct packed {
    logic [7:0]  device_id;
    logic [15:0] reg_address;
    logic [63:0] data_word;
    logic [3:0]  data_length;
    logic [2:0]  req_type;
  } cfb_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       length_error;
  } cfb_out_t;

  typedef struct packed {
    logic       clr;
    logic       en;
    logic [7:0] data_byte;
  } cfb_crc_ctl_t;

endpackage

`default_nettype wire

>>> sv/cfb_crc.sv
// CRC-16/ARC accumulator, one frame byte per cycle while en is set.
// Depends on cfb_pkg for the control struct and the polynomial.
`default_nettype none

module cfb_crc (
  input  wire                   clk,
  input  cfb_pkg::cfb_crc_ctl_t ctl,
  output logic [15:0]           crc
);
  import cfb_pkg::*;

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  // reflected CRC: fold in one byte, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY_REFL;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  always_comb begin
    crc_nxt = crc_r;
    if (ctl.clr) begin
      crc_nxt = 16'h0000;
    end else if (ctl.en) begin
      crc_nxt = crc_byte(crc_r, ctl.data_byte);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule

`default_nettype wire

>>> sv/command_frame_builder_crc16.sv
// Order: an accepted command first loads the sequencer state (S_HDR), then the output
//   register strobes the first byte; a length error result is strobed in the cycle
//   right after the accepting edge. A frame is 5 to 14 bytes, one byte per cycle from
//   the byte sequencer and the byte-wide CRC step; no new command is taken while busy.
// Reset: rst_n is synchronous, active low; it returns the sequencer to idle and drops
//   the strobe. The receiver cannot stall; every result is shown for exactly one cycle.
`default_nettype none

module command_frame_builder_crc16 #(
  parameter int unsigned MAX_DATA_BYTES = cfb_pkg::MAX_DATA_BYTES_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  cfb_pkg::cfb_in_t  in_item,
  output logic              out_valid,
  output cfb_pkg::cfb_out_t out_item
);
  import cfb_pkg::*;

  localparam int unsigned DATA_W = 8 * MAX_DATA_BYTES;
  localparam int unsigned LEN_W  = $clog2(MAX_DATA_BYTES + 1);

  // one-hot byte sequencer: one state per frame field
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_HDR  = 8'b0000_0010,
    S_DEV  = 8'b0000_0100,
    S_AHI  = 8'b0000_1000,
    S_ALO  = 8'b0001_0000,
    S_DATA = 8'b0010_0000,
    S_CLO  = 8'b0100_0000,
    S_CHI  = 8'b1000_0000
  } cfb_state_t;

  cfb_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  cfb_out_t   out_r, out_nxt;

  // command fields held for the frame
  logic [7:0]        hdr_r, hdr_nxt;
  logic [7:0]        dev_r, dev_nxt;
  logic [15:0]       addr_r, addr_nxt;
  logic              wide_r, wide_nxt;
  logic              has_dev_r, has_dev_nxt;
  logic [DATA_W-1:0] data_sr_r, data_sr_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;

  logic         accept;
  logic         len_bad;
  logic         in_wide;
  logic [2:0]   len_code;
  logic [LEN_W-1:0] pad_bytes;
  logic [7:0]   emit_byte;
  logic         emit;
  logic         emit_last;
  logic         crc_feed;
  cfb_crc_ctl_t crc_ctl;
  logic [15:0]  crc;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // reject zero, seven and anything past the configured payload size
  assign len_bad = (in_item.data_length == 4'd0) ||
                   (in_item.data_length == LEN_SEVEN) ||
                   (in_item.data_length > 4'(MAX_DATA_BYTES));
  assign in_wide  = |in_item.reg_address[15:8];
  // length eight is coded as seven in the header
  assign len_code = (in_item.data_length == LEN_EIGHT) ? LEN_CODE_MAX
                                                        : in_item.data_length[2:0];
  // left-align the payload so the first byte to send sits at the top
  assign pad_bytes = LEN_W'(MAX_DATA_BYTES) - in_item.data_length[LEN_W-1:0];

  cfb_crc u_crc (
    .clk (clk),
    .ctl (crc_ctl),
    .crc (crc)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    hdr_nxt       = hdr_r;
    dev_nxt       = dev_r;
    addr_nxt      = addr_r;
    wide_nxt      = wide_r;
    has_dev_nxt   = has_dev_r;
    data_sr_nxt   = data_sr_r;
    cnt_nxt       = cnt_r;
    emit          = 1'b0;
    emit_byte     = 8'h00;
    emit_last     = 1'b0;
    crc_feed      = 1'b0;
    crc_ctl       = '{clr: 1'b0, en: 1'b0, data_byte: 8'h00};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (len_bad) begin
            // single error item, no frame
            out_valid_nxt = 1'b1;
            out_nxt       = '{frame_byte: 8'h00, last_byte: 1'b1, length_error: 1'b1};
          end else begin
            hdr_nxt     = HDR_BASE | {1'b0, in_item.req_type, 4'h0} |
                          (in_wide ? HDR_WIDE_ADDR : 8'h00) | {5'h00, len_code};
            dev_nxt     = in_item.device_id;
            addr_nxt    = in_item.reg_address;
            wide_nxt    = in_wide;
            has_dev_nxt = !in_item.req_type[2];
            data_sr_nxt = in_item.data_word[DATA_W-1:0] << {pad_bytes, 3'b000};
            cnt_nxt     = in_item.data_length[LEN_W-1:0];
            crc_ctl.clr = 1'b1;
            state_nxt   = S_HDR;
          end
        end
      end
      S_HDR: begin
        emit      = 1'b1;
        crc_feed  = 1'b1;
        emit_byte = hdr_r;
        if (has_dev_r) begin
          state_nxt = S_DEV;
        end else if (wide_r) begin
          state_nxt = S_AHI;
        end else begin
          state_nxt = S_ALO;
        end
      end
      S_DEV: begin
        emit      = 1'b1;
        crc_feed  = 1'b1;
        emit_byte = dev_r;
        state_nxt = wide_r ? S_AHI : S_ALO;
      end
      S_AHI: begin
        emit      = 1'b1;
        crc_feed  = 1'b1;
        emit_byte = addr_r[15:8];
        state_nxt = S_ALO;
      end
      S_ALO: begin
        emit      = 1'b1;
        crc_feed  = 1'b1;
        emit_byte = addr_r[7:0];
        state_nxt = S_DATA;
      end
      S_DATA: begin
        // shift one payload byte out per cycle
        emit        = 1'b1;
        crc_feed    = 1'b1;
        emit_byte   = data_sr_r[DATA_W-1 -: 8];
        data_sr_nxt = data_sr_r << 8;
        cnt_nxt     = cnt_r - LEN_W'(1);
        if (cnt_r == LEN_W'(1)) begin
          state_nxt = S_CLO;
        end
      end
      S_CLO: begin
        emit      = 1'b1;
        emit_byte = crc[7:0];
        state_nxt = S_CHI;
      end
      S_CHI: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        emit_byte = crc[15:8];
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '{frame_byte: emit_byte, last_byte: emit_last, length_error: 1'b0};
    end
    if (crc_feed) begin
      crc_ctl.en        = 1'b1;
      crc_ctl.data_byte = emit_byte;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_r     <= out_nxt;
    hdr_r     <= hdr_nxt;
    dev_r     <= dev_nxt;
    addr_r    <= addr_nxt;
    wide_r    <= wide_nxt;
    has_dev_r <= has_dev_nxt;
    data_sr_r <= data_sr_nxt;
    cnt_r     <= cnt_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef ASSERT_OFF
  a_err_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept && len_bad |=> out_valid && out_item.length_error && out_item.last_byte)
    else $error("length error item missing after rejected command");

  a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !len_bad |=> busy && !out_valid)
    else $error("frame did not start after accepted command");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_byte && !out_item.length_error |-> !busy)
    else $error("sequencer still busy after final frame byte");

  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) ##1 out_valid |-> $past(busy) || $past(start))
    else $error("result strobe without a command in progress");
`endif

endmodule

`default_nettype wire
